FILE: design/smm_pkg.sv
// ============================================================================
// smm_pkg
// Shared types, sizes and codes for the sparse matrix multiply core.
// ============================================================================
`default_nettype none

package smm_pkg;

    // Sizes
    localparam int MAX_DIM    = 8;
    localparam int MAX_NZ     = 64;
    localparam int IDX_W      = 3;                      // row / column index
    localparam int DIM_W      = 4;                      // size registers
    localparam int FILL_W     = $clog2(MAX_NZ + 1);     // fill counts
    localparam int VAL_W      = 32;
    localparam int IN_DATA_W  = 40;                     // row, col, value + pad
    localparam int OUT_DATA_W = 40;                     // out_row, out_col, out_value + pad

    // Operation codes (s_tuser)
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    // One stored triplet, row in the top bits
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } smm_entry_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic             clear;    // zero the accumulator row
        logic             mul_en;   // capture product and its column
        logic             add_en;   // add captured product into its column
        logic [IDX_W-1:0] idx;      // column for mul_en, or scan read column
    } smm_mac_ctl_t;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ROW  = 9'b000000010,
        S_AIDX = 9'b000000100,
        S_ACHK = 9'b000001000,
        S_BIDX = 9'b000010000,
        S_BCHK = 9'b000100000,
        S_ACC  = 9'b001000000,
        S_SCAN = 9'b010000000,
        S_FIN  = 9'b100000000
    } smm_state_t;

    // Effective size: register clamped to MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] cnt);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (cnt < lim) ? cnt : lim;
    endfunction

endpackage

`default_nettype wire

FILE: design/smm_ram.sv
// ============================================================================
// smm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module smm_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/smm_mac.sv
// ============================================================================
// smm_mac
// Shared multiplier with a product register, plus the dense accumulator row.
// ============================================================================
`default_nettype none

module smm_mac
    import smm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire smm_mac_ctl_t     ctl,
    input  wire logic [VAL_W-1:0] a_val,
    input  wire logic [VAL_W-1:0] b_val,
    output logic      [VAL_W-1:0] acc_word
);

    logic [VAL_W-1:0] acc_reg [MAX_DIM];
    logic [VAL_W-1:0] prod_reg;
    logic [IDX_W-1:0] pcol_reg;
    logic [IDX_W-1:0] rd_sel;
    logic [VAL_W-1:0] prod_next;

    // Low 32 bits of the product; same for signed and unsigned
    assign prod_next = a_val * b_val;

    // One read port: product column during an add, scan column otherwise
    assign rd_sel   = ctl.add_en ? pcol_reg : ctl.idx;
    assign acc_word = acc_reg[rd_sel];

    // Product stage
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
            pcol_reg <= ctl.idx;
        end
    end

    // Accumulator row
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (ctl.add_en) begin
            acc_reg[pcol_reg] <= acc_word + prod_reg;
        end
    end

endmodule

`default_nettype wire

FILE: design/sparse_matrix_multiply_core.sv
// ============================================================================
// sparse_matrix_multiply_core
// Sparse matrix product C = A x B over coordinate triplets, row accumulation.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser op, tdata row,col,value
//  m_      | out | m_tvalid/m_tready  | tdata out_row,out_col,out_value,
//          |     |                    | tlast last, tuser empty_res
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (size registers)
//
//  A load beat is taken whenever the core is idle. For each of the m rows a
//  compute beat walks all A triplets and, for every A triplet in that row, all
//  B triplets, multiplying each matching pair on the one multiplier into the
//  accumulator row, then scans that row for nonzero results; a closing step
//  sends the last beat (it is reached at once on a size mismatch). The core is
//  not ready during a compute. A stalled result holds the scan only when an
//  entry is already pending and another nonzero column comes up; the closing
//  state waits for the result register. No clearing pass after reset.
//
`default_nettype none

module sparse_matrix_multiply_core
    import smm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] row, [5:3] col, [37:6] value
    input  wire logic [1:0]            s_tuser,   // [1:0] operation
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // [2:0] out_row, [5:3] out_col,
                                                  // [37:6] out_value
    output logic                       m_tlast,
    output logic                       m_tuser,   // [0] empty_res
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_data
);

    localparam int NZ_A_W = $clog2(MAX_NZ);

    smm_state_t       state_reg, state_next;
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [FILL_W-1:0] a_fill_reg, b_fill_reg;
    logic [FILL_W-1:0] i_reg, j_reg;
    logic [DIM_W-1:0] r_reg, c_reg;

    logic             pend_valid_reg;
    logic [IDX_W-1:0] pend_row_reg, pend_col_reg;
    logic [VAL_W-1:0] pend_val_reg;

    logic             out_valid_reg, out_last_reg, out_empty_reg;
    logic [IDX_W-1:0] out_row_reg, out_col_reg;
    logic [VAL_W-1:0] out_val_reg;

    smm_entry_t   in_ent, a_ent, b_ent;
    smm_mac_ctl_t mac_ctl;
    logic [VAL_W-1:0] acc_word;
    logic [DIM_W-1:0] m_dim, n_dim, p_dim;
    logic in_fire, a_we, b_we, out_busy, acc_nz, scan_done, scan_hold;
    logic a_match, b_match, dims_ok, out_push;

    // Input beat fields
    assign in_ent.row   = s_tdata[2:0];
    assign in_ent.col   = s_tdata[5:3];
    assign in_ent.value = s_tdata[37:6];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    assign m_dim   = eff_dim(a_rows_reg);
    assign n_dim   = eff_dim(a_cols_reg);
    assign p_dim   = eff_dim(b_cols_reg);
    assign dims_ok = (a_cols_reg == b_rows_reg);

    // Load acceptance: in range and room left
    assign a_we = in_fire && (s_tuser == OP_LOAD_A)
               && ({1'b0, in_ent.row} < eff_dim(a_rows_reg))
               && ({1'b0, in_ent.col} < eff_dim(a_cols_reg))
               && (a_fill_reg < FILL_W'(MAX_NZ));
    assign b_we = in_fire && (s_tuser == OP_LOAD_B)
               && ({1'b0, in_ent.row} < eff_dim(b_rows_reg))
               && ({1'b0, in_ent.col} < eff_dim(b_cols_reg))
               && (b_fill_reg < FILL_W'(MAX_NZ));

    // Triplet stores
    smm_ram #(
        .WIDTH ($bits(smm_entry_t)),
        .DEPTH (MAX_NZ)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_fill_reg[NZ_A_W-1:0]),
        .wdata (in_ent),
        .raddr (i_reg[NZ_A_W-1:0]),
        .rdata (a_ent)
    );

    smm_ram #(
        .WIDTH ($bits(smm_entry_t)),
        .DEPTH (MAX_NZ)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_fill_reg[NZ_A_W-1:0]),
        .wdata (in_ent),
        .raddr (j_reg[NZ_A_W-1:0]),
        .rdata (b_ent)
    );

    smm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .a_val    (a_ent.value),
        .b_val    (b_ent.value),
        .acc_word (acc_word)
    );

    // Match and scan conditions
    assign a_match   = ({1'b0, a_ent.row} == r_reg) && ({1'b0, a_ent.col} < n_dim);
    assign b_match   = (b_ent.row == a_ent.col) && ({1'b0, b_ent.col} < p_dim);
    assign out_busy  = out_valid_reg && !m_tready;
    assign acc_nz    = |acc_word;
    assign scan_done = (c_reg == p_dim);
    assign scan_hold = !scan_done && acc_nz && pend_valid_reg && out_busy;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        mac_ctl.clear  = 1'b0;
        mac_ctl.mul_en = 1'b0;
        mac_ctl.add_en = 1'b0;
        mac_ctl.idx    = c_reg[IDX_W-1:0];
        out_push       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_tuser == OP_COMPUTE)) begin
                    state_next = dims_ok ? S_ROW : S_FIN;
                end
            end
            S_ROW: begin
                mac_ctl.clear = (r_reg != m_dim);
                state_next    = (r_reg == m_dim) ? S_FIN : S_AIDX;
            end
            S_AIDX: begin
                state_next = (i_reg == a_fill_reg) ? S_SCAN : S_ACHK;
            end
            S_ACHK: begin
                state_next = a_match ? S_BIDX : S_AIDX;
            end
            S_BIDX: begin
                state_next = (j_reg == b_fill_reg) ? S_AIDX : S_BCHK;
            end
            S_BCHK: begin
                mac_ctl.mul_en = b_match;
                mac_ctl.idx    = b_ent.col;
                state_next     = b_match ? S_ACC : S_BIDX;
            end
            S_ACC: begin
                mac_ctl.add_en = 1'b1;
                state_next     = S_BIDX;
            end
            S_SCAN: begin
                out_push   = !scan_done && acc_nz && pend_valid_reg && !out_busy;
                state_next = scan_done ? S_ROW : S_SCAN;
            end
            S_FIN: begin
                out_push   = !out_busy;
                state_next = out_busy ? S_FIN : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            a_rows_reg     <= DIM_W'(MAX_DIM);
            a_cols_reg     <= DIM_W'(MAX_DIM);
            b_rows_reg     <= DIM_W'(MAX_DIM);
            b_cols_reg     <= DIM_W'(MAX_DIM);
            a_fill_reg     <= '0;
            b_fill_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // size registers
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_A_ROWS: a_rows_reg <= cfg_data;
                    CFG_A_COLS: a_cols_reg <= cfg_data;
                    CFG_B_ROWS: b_rows_reg <= cfg_data;
                    CFG_B_COLS: b_cols_reg <= cfg_data;
                    default:    a_rows_reg <= a_rows_reg;
                endcase
            end

            if (a_we) a_fill_reg <= a_fill_reg + 1'b1;
            if (b_we) b_fill_reg <= b_fill_reg + 1'b1;

            // result register drains on ready
            if (out_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_fire && (s_tuser == OP_COMPUTE)) begin
                        r_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                    end
                end
                S_ROW: begin
                    i_reg <= '0;
                end
                S_AIDX: begin
                    c_reg <= '0;
                end
                S_ACHK: begin
                    if (a_match) begin
                        j_reg <= '0;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_BIDX: begin
                    if (j_reg == b_fill_reg) i_reg <= i_reg + 1'b1;
                end
                S_BCHK: begin
                    if (!b_match) j_reg <= j_reg + 1'b1;
                end
                S_ACC: begin
                    j_reg <= j_reg + 1'b1;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_reg <= r_reg + 1'b1;
                    end else if (!scan_hold) begin
                        c_reg <= c_reg + 1'b1;
                        if (acc_nz) pend_valid_reg <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (!out_busy) begin
                        a_fill_reg     <= '0;
                        b_fill_reg     <= '0;
                        pend_valid_reg <= 1'b0;
                    end
                end
                default: begin
                    r_reg <= '0;
                end
            endcase
        end
    end

    // Pending entry and result payload
    always_ff @(posedge aclk) begin
        if ((state_reg == S_SCAN) && !scan_done && acc_nz && !scan_hold) begin
            pend_row_reg <= r_reg[IDX_W-1:0];
            pend_col_reg <= c_reg[IDX_W-1:0];
            pend_val_reg <= acc_word;
        end
        if (out_push) begin
            if (pend_valid_reg) begin
                out_row_reg   <= pend_row_reg;
                out_col_reg   <= pend_col_reg;
                out_val_reg   <= pend_val_reg;
                out_empty_reg <= 1'b0;
            end else begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_val_reg   <= '0;
                out_empty_reg <= 1'b1;
            end
            out_last_reg <= (state_reg == S_FIN);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fill_reg <= FILL_W'(MAX_NZ)) && (b_fill_reg <= FILL_W'(MAX_NZ)))
        else $error("triplet fill count beyond store depth");

    busy_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_COMPUTE)) |=> !s_tready)
        else $error("input taken right after a compute beat");

    stores_emptied: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIN) && !out_busy) |=> (a_fill_reg == '0) && (b_fill_reg == '0))
        else $error("stores not emptied after compute");

    empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty result not marked last");
`endif

endmodule

`default_nettype wire
